[src/lphr_pkg.sv]
package lphr_pkg;

   localparam int MAX_LAYERS_DEF = 8;
   localparam int COORD_BITS_DEF = 12;
   localparam int CFG_BITS       = 4;

   localparam logic OP_LOAD    = 1'b0;
   localparam logic OP_RESOLVE = 1'b1;

   // control that travels down the chain with each item
   typedef struct packed {
      logic valid;
      logic resolve;
   } stage_ctrl_type;

endpackage

[src/lphr_cell.sv]
// One layer slot. Holds its rectangle, captures a load addressed to it,
// and folds its coverage and extent into a passing resolve item.
module lphr_cell #(
   parameter int CELL_INDEX = 0,
   parameter int COORD_BITS = lphr_pkg::COORD_BITS_DEF,
   parameter int IDX_BITS   = 3
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               advance,
   input  logic [lphr_pkg::CFG_BITS-1:0]      active_layers,
   input  lphr_pkg::stage_ctrl_type           ctrl_in,
   input  logic [IDX_BITS-1:0]                entry_index_in,
   input  logic [COORD_BITS-1:0]              origin_x_in,
   input  logic [COORD_BITS-1:0]              origin_y_in,
   input  logic [COORD_BITS:0]                extent_w_in,
   input  logic [COORD_BITS:0]                extent_h_in,
   input  logic [COORD_BITS-1:0]              pixel_x_in,
   input  logic [COORD_BITS-1:0]              pixel_y_in,
   input  logic                               hit_in,
   input  logic [IDX_BITS-1:0]                win_in,
   input  logic [COORD_BITS-1:0]              local_x_in,
   input  logic [COORD_BITS-1:0]              local_y_in,
   input  logic [COORD_BITS:0]                canvas_w_in,
   input  logic [COORD_BITS:0]                canvas_h_in,
   output lphr_pkg::stage_ctrl_type           ctrl_out,
   output logic [IDX_BITS-1:0]                entry_index_out,
   output logic [COORD_BITS-1:0]              origin_x_out,
   output logic [COORD_BITS-1:0]              origin_y_out,
   output logic [COORD_BITS:0]                extent_w_out,
   output logic [COORD_BITS:0]                extent_h_out,
   output logic [COORD_BITS-1:0]              pixel_x_out,
   output logic [COORD_BITS-1:0]              pixel_y_out,
   output logic                               hit_out,
   output logic [IDX_BITS-1:0]                win_out,
   output logic [COORD_BITS-1:0]              local_x_out,
   output logic [COORD_BITS-1:0]              local_y_out,
   output logic [COORD_BITS:0]                canvas_w_out,
   output logic [COORD_BITS:0]                canvas_h_out
);

   // stored rectangle
   logic [COORD_BITS-1:0] left_ff, top_ff;
   logic [COORD_BITS:0]   width_ff, height_ff;

   // item registers
   lphr_pkg::stage_ctrl_type ctrl_ff;
   logic [IDX_BITS-1:0]   entry_index_ff;
   logic [COORD_BITS-1:0] origin_x_ff, origin_y_ff, pixel_x_ff, pixel_y_ff;
   logic [COORD_BITS:0]   extent_w_ff, extent_h_ff;
   logic                  hit_ff;
   logic [IDX_BITS-1:0]   win_ff;
   logic [COORD_BITS-1:0] local_x_ff, local_y_ff;
   logic [COORD_BITS:0]   canvas_w_ff, canvas_h_ff;

   logic                  hit_in_next;
   logic [IDX_BITS-1:0]   win_in_next;
   logic [COORD_BITS-1:0] local_x_in_next, local_y_in_next;
   logic [COORD_BITS:0]   canvas_w_in_next, canvas_h_in_next;

   logic [COORD_BITS+1:0] right, bottom;
   logic [COORD_BITS:0]   right_sat, bottom_sat;
   logic                  slot_active, covers, load_here;

   always_comb begin
      right      = {2'b00, left_ff} + {1'b0, width_ff};
      bottom     = {2'b00, top_ff} + {1'b0, height_ff};
      right_sat  = right[COORD_BITS+1] ? '1 : right[COORD_BITS:0];
      bottom_sat = bottom[COORD_BITS+1] ? '1 : bottom[COORD_BITS:0];
      slot_active = ctrl_in.resolve && (CELL_INDEX < int'(active_layers));
      covers = (left_ff <= pixel_x_in) && ({2'b00, pixel_x_in} < right) &&
               (top_ff <= pixel_y_in) && ({2'b00, pixel_y_in} < bottom);
      load_here = ctrl_in.valid && !ctrl_in.resolve &&
                  (entry_index_in == IDX_BITS'(CELL_INDEX));

      hit_in_next      = hit_in;
      win_in_next      = win_in;
      local_x_in_next  = local_x_in;
      local_y_in_next  = local_y_in;
      canvas_w_in_next = canvas_w_in;
      canvas_h_in_next = canvas_h_in;
      if (slot_active) begin
         if (right_sat > canvas_w_in) begin
            canvas_w_in_next = right_sat;
         end
         if (bottom_sat > canvas_h_in) begin
            canvas_h_in_next = bottom_sat;
         end
         // later slot overrides: last drawn wins
         if (covers) begin
            hit_in_next     = 1'b1;
            win_in_next     = IDX_BITS'(CELL_INDEX);
            local_x_in_next = pixel_x_in - left_ff;
            local_y_in_next = pixel_y_in - top_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff   <= '0;
         top_ff    <= '0;
         width_ff  <= '0;
         height_ff <= '0;
      end else if (advance && load_here) begin
         left_ff   <= origin_x_in;
         top_ff    <= origin_y_in;
         width_ff  <= extent_w_in;
         height_ff <= extent_h_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else if (advance) begin
         ctrl_ff <= ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         entry_index_ff <= entry_index_in;
         origin_x_ff    <= origin_x_in;
         origin_y_ff    <= origin_y_in;
         extent_w_ff    <= extent_w_in;
         extent_h_ff    <= extent_h_in;
         pixel_x_ff     <= pixel_x_in;
         pixel_y_ff     <= pixel_y_in;
         hit_ff         <= hit_in_next;
         win_ff         <= win_in_next;
         local_x_ff     <= local_x_in_next;
         local_y_ff     <= local_y_in_next;
         canvas_w_ff    <= canvas_w_in_next;
         canvas_h_ff    <= canvas_h_in_next;
      end
   end

   assign ctrl_out        = ctrl_ff;
   assign entry_index_out = entry_index_ff;
   assign origin_x_out    = origin_x_ff;
   assign origin_y_out    = origin_y_ff;
   assign extent_w_out    = extent_w_ff;
   assign extent_h_out    = extent_h_ff;
   assign pixel_x_out     = pixel_x_ff;
   assign pixel_y_out     = pixel_y_ff;
   assign hit_out         = hit_ff;
   assign win_out         = win_ff;
   assign local_x_out     = local_x_ff;
   assign local_y_out     = local_y_ff;
   assign canvas_w_out    = canvas_w_ff;
   assign canvas_h_out    = canvas_h_ff;

endmodule

[src/lphr_rsp_reg.sv]
// Output register: holds one finished result until it is taken.
module lphr_rsp_reg #(
   parameter int COORD_BITS = lphr_pkg::COORD_BITS_DEF,
   parameter int IDX_BITS   = 3
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  logic                  hit_in,
   input  logic [IDX_BITS-1:0]   win_in,
   input  logic [COORD_BITS-1:0] local_x_in,
   input  logic [COORD_BITS-1:0] local_y_in,
   input  logic [COORD_BITS:0]   canvas_w_in,
   input  logic [COORD_BITS:0]   canvas_h_in,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic                  rsp_hit,
   output logic [IDX_BITS-1:0]   rsp_winning_layer,
   output logic [COORD_BITS-1:0] rsp_local_x,
   output logic [COORD_BITS-1:0] rsp_local_y,
   output logic [COORD_BITS:0]   rsp_canvas_width,
   output logic [COORD_BITS:0]   rsp_canvas_height
);

   logic                  valid_ff;
   logic                  hit_ff;
   logic [IDX_BITS-1:0]   win_ff;
   logic [COORD_BITS-1:0] local_x_ff, local_y_ff;
   logic [COORD_BITS:0]   canvas_w_ff, canvas_h_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         hit_ff      <= hit_in;
         win_ff      <= win_in;
         local_x_ff  <= local_x_in;
         local_y_ff  <= local_y_in;
         canvas_w_ff <= canvas_w_in;
         canvas_h_ff <= canvas_h_in;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_hit           = hit_ff;
   assign rsp_winning_layer = win_ff;
   assign rsp_local_x       = local_x_ff;
   assign rsp_local_y       = local_y_ff;
   assign rsp_canvas_width  = canvas_w_ff;
   assign rsp_canvas_height = canvas_h_ff;

endmodule

[src/layer_priority_hit_resolver_top.sv]
// Layer priority hit resolver. Every item walks a chain of MAX_LAYERS cells,
// one cell per clock unless stalled, and resolve items then land in an output
// register. Cell k holds layer rectangle k. A load item (operation 0) is
// captured by the cell whose index matches entry_index and gives no result;
// indexes with no cell are dropped. A resolve item (operation 1) picks up, in
// each active cell, that layer's right/bottom extent for the canvas size and,
// if the layer covers the pixel, the layer index and local coordinates, so the
// highest covering layer wins. Throughput is one item per clock unless
// stalled. Because loads travel the same chain, every item sees exactly the
// table left by the items accepted before it. The chain stalls only while a
// result waits in the output register and another finished result is behind
// it. active_layers (values above MAX_LAYERS act as MAX_LAYERS) must be
// written only while the block is idle. Canvas sizes saturate at all ones of
// their COORD_BITS+1 bit field.
module layer_priority_hit_resolver_top #(
   parameter int MAX_LAYERS = lphr_pkg::MAX_LAYERS_DEF,
   parameter int COORD_BITS = lphr_pkg::COORD_BITS_DEF,
   parameter int IDX_BITS   = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1
) (
   input  logic                              clock,
   input  logic                              reset,
   // configuration
   input  logic                              csr_write_enable,
   input  logic [lphr_pkg::CFG_BITS-1:0]     csr_write_data,
   // request channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_operation,
   input  logic [IDX_BITS-1:0]               req_entry_index,
   input  logic [COORD_BITS-1:0]             req_origin_x,
   input  logic [COORD_BITS-1:0]             req_origin_y,
   input  logic [COORD_BITS:0]               req_extent_w,
   input  logic [COORD_BITS:0]               req_extent_h,
   input  logic [COORD_BITS-1:0]             req_pixel_x,
   input  logic [COORD_BITS-1:0]             req_pixel_y,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_hit,
   output logic [IDX_BITS-1:0]               rsp_winning_layer,
   output logic [COORD_BITS-1:0]             rsp_local_x,
   output logic [COORD_BITS-1:0]             rsp_local_y,
   output logic [COORD_BITS:0]               rsp_canvas_width,
   output logic [COORD_BITS:0]               rsp_canvas_height
);

   logic [lphr_pkg::CFG_BITS-1:0] active_layers_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_layers_ff <= '0;
      end else if (csr_write_enable) begin
         active_layers_ff <= csr_write_data;
      end
   end

   // stage signals: index 0 is the request, index MAX_LAYERS the chain tail
   lphr_pkg::stage_ctrl_type ctrl   [MAX_LAYERS+1];
   logic [IDX_BITS-1:0]      eidx   [MAX_LAYERS+1];
   logic [COORD_BITS-1:0]    org_x  [MAX_LAYERS+1];
   logic [COORD_BITS-1:0]    org_y  [MAX_LAYERS+1];
   logic [COORD_BITS:0]      ext_w  [MAX_LAYERS+1];
   logic [COORD_BITS:0]      ext_h  [MAX_LAYERS+1];
   logic [COORD_BITS-1:0]    pix_x  [MAX_LAYERS+1];
   logic [COORD_BITS-1:0]    pix_y  [MAX_LAYERS+1];
   logic                     hit    [MAX_LAYERS+1];
   logic [IDX_BITS-1:0]      win    [MAX_LAYERS+1];
   logic [COORD_BITS-1:0]    loc_x  [MAX_LAYERS+1];
   logic [COORD_BITS-1:0]    loc_y  [MAX_LAYERS+1];
   logic [COORD_BITS:0]      cnv_w  [MAX_LAYERS+1];
   logic [COORD_BITS:0]      cnv_h  [MAX_LAYERS+1];

   logic advance;
   logic tail_result;

   // a result at the tail can only move if the output register frees up
   assign tail_result = ctrl[MAX_LAYERS].valid && ctrl[MAX_LAYERS].resolve;
   assign advance     = !(tail_result && rsp_valid && !rsp_ready);
   assign req_ready   = advance;

   assign ctrl[0].valid   = req_valid;
   assign ctrl[0].resolve = (req_operation == lphr_pkg::OP_RESOLVE);
   assign eidx[0]  = req_entry_index;
   assign org_x[0] = req_origin_x;
   assign org_y[0] = req_origin_y;
   assign ext_w[0] = req_extent_w;
   assign ext_h[0] = req_extent_h;
   assign pix_x[0] = req_pixel_x;
   assign pix_y[0] = req_pixel_y;
   assign hit[0]   = 1'b0;
   assign win[0]   = '0;
   assign loc_x[0] = '0;
   assign loc_y[0] = '0;
   assign cnv_w[0] = '0;
   assign cnv_h[0] = '0;

   for (genvar k = 0; k < MAX_LAYERS; k++) begin : g_cell
      lphr_cell #(
         .CELL_INDEX (k),
         .COORD_BITS (COORD_BITS),
         .IDX_BITS   (IDX_BITS)
      ) u_cell (
         .clock           (clock),
         .reset           (reset),
         .advance         (advance),
         .active_layers   (active_layers_ff),
         .ctrl_in         (ctrl[k]),
         .entry_index_in  (eidx[k]),
         .origin_x_in     (org_x[k]),
         .origin_y_in     (org_y[k]),
         .extent_w_in     (ext_w[k]),
         .extent_h_in     (ext_h[k]),
         .pixel_x_in      (pix_x[k]),
         .pixel_y_in      (pix_y[k]),
         .hit_in          (hit[k]),
         .win_in          (win[k]),
         .local_x_in      (loc_x[k]),
         .local_y_in      (loc_y[k]),
         .canvas_w_in     (cnv_w[k]),
         .canvas_h_in     (cnv_h[k]),
         .ctrl_out        (ctrl[k+1]),
         .entry_index_out (eidx[k+1]),
         .origin_x_out    (org_x[k+1]),
         .origin_y_out    (org_y[k+1]),
         .extent_w_out    (ext_w[k+1]),
         .extent_h_out    (ext_h[k+1]),
         .pixel_x_out     (pix_x[k+1]),
         .pixel_y_out     (pix_y[k+1]),
         .hit_out         (hit[k+1]),
         .win_out         (win[k+1]),
         .local_x_out     (loc_x[k+1]),
         .local_y_out     (loc_y[k+1]),
         .canvas_w_out    (cnv_w[k+1]),
         .canvas_h_out    (cnv_h[k+1])
      );
   end

   lphr_rsp_reg #(
      .COORD_BITS (COORD_BITS),
      .IDX_BITS   (IDX_BITS)
   ) u_rsp (
      .clock             (clock),
      .reset             (reset),
      .load              (tail_result && advance),
      .hit_in            (hit[MAX_LAYERS]),
      .win_in            (win[MAX_LAYERS]),
      .local_x_in        (loc_x[MAX_LAYERS]),
      .local_y_in        (loc_y[MAX_LAYERS]),
      .canvas_w_in       (cnv_w[MAX_LAYERS]),
      .canvas_h_in       (cnv_h[MAX_LAYERS]),
      .rsp_ready         (rsp_ready),
      .rsp_valid         (rsp_valid),
      .rsp_hit           (rsp_hit),
      .rsp_winning_layer (rsp_winning_layer),
      .rsp_local_x       (rsp_local_x),
      .rsp_local_y       (rsp_local_y),
      .rsp_canvas_width  (rsp_canvas_width),
      .rsp_canvas_height (rsp_canvas_height)
   );

   // a miss carries zero index and zero local coordinates
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |->
         rsp_winning_layer == '0 && rsp_local_x == '0 && rsp_local_y == '0)
      else $error("miss result with nonzero index or local coordinates");

   // the chain only stalls behind a result that is not being taken
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready && tail_result)
      else $error("request stalled without a blocked result");

   // a stalled tail result is still there next cycle
   a_tail_held: assert property (@(posedge clock) disable iff (reset)
      !advance |=> tail_result)
      else $error("stalled tail result lost");

   // output register comes out of reset empty
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

[tb/sv/tb_layer_priority_hit_resolver_top.sv]
module tb_layer_priority_hit_resolver_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_L        = lphr_pkg::MAX_LAYERS_DEF;
   localparam int CB           = lphr_pkg::COORD_BITS_DEF;
   localparam int CFG_W        = lphr_pkg::CFG_BITS;
   localparam int IB           = (MAX_L > 1) ? $clog2(MAX_L) : 1;
   localparam int CMAX         = (1 << CB) - 1;        // largest coordinate
   localparam int EMAX         = (1 << (CB + 1)) - 1;  // largest extent / canvas size
   localparam int PERIOD       = 20;
   localparam int NO_CSR       = -1;                   // row leaves active_layers alone
   localparam int DRAIN_CYCLES = MAX_L + 8;            // chain length plus slack
   localparam int LONG_HOLD    = 300;
   localparam int PHASE_ITEMS  = 250;
   localparam int NUM_PHASES   = 6;
   localparam int LIMIT        = 300000;

   // one request item, all fields carried whatever the operation
   typedef struct packed {
      logic          op;
      logic [IB-1:0] entry;
      logic [CB-1:0] ox;
      logic [CB-1:0] oy;
      logic [CB:0]   ew;
      logic [CB:0]   eh;
      logic [CB-1:0] px;
      logic [CB-1:0] py;
   } req_item_type;

   // one resolve result
   typedef struct packed {
      logic          hit;
      logic [IB-1:0] layer;
      logic [CB-1:0] lx;
      logic [CB-1:0] ly;
      logic [CB:0]   cw;
      logic [CB:0]   ch;
   } hit_result_type;

   // directed stimulus row; result is only used when fixed is set
   typedef struct {
      int             csr;
      req_item_type   item;
      bit             fixed;
      hit_result_type result;
   } vector_row_type;

   // ---------------------------------------------------------------
   // DUT signals; all inputs are known from time zero
   // ---------------------------------------------------------------
   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_write_enable = 1'b0;
   logic [CFG_W-1:0]    csr_write_data = '0;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic                req_operation = lphr_pkg::OP_LOAD;
   logic [IB-1:0]       req_entry_index = '0;
   logic [CB-1:0]       req_origin_x = '0;
   logic [CB-1:0]       req_origin_y = '0;
   logic [CB:0]         req_extent_w = '0;
   logic [CB:0]         req_extent_h = '0;
   logic [CB-1:0]       req_pixel_x = '0;
   logic [CB-1:0]       req_pixel_y = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic                rsp_hit;
   logic [IB-1:0]       rsp_winning_layer;
   logic [CB-1:0]       rsp_local_x;
   logic [CB-1:0]       rsp_local_y;
   logic [CB:0]         rsp_canvas_width;
   logic [CB:0]         rsp_canvas_height;

   // ---------------------------------------------------------------
   // Predictor state: shadow layer table and active count
   // ---------------------------------------------------------------
   logic [CB-1:0]       left_edge [MAX_L] = '{default: '0};
   logic [CB-1:0]       top_edge  [MAX_L] = '{default: '0};
   logic [CB:0]         width     [MAX_L] = '{default: '0};
   logic [CB:0]         height    [MAX_L] = '{default: '0};
   logic [CFG_W-1:0]    layers_reg = '0;

   hit_result_type      pending_hits [$];   // resolve results still owed by the DUT
   vector_row_type      dir_rows [$];
   int                  mismatches = 0;
   int                  cycles = 0;
   bit                  idle_on = 1'b1;     // random idling on both sides
   bit                  hold_rsp = 1'b0;    // request for one long receiver hold

   layer_priority_hit_resolver_top i_dut (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_operation     (req_operation),
      .req_entry_index   (req_entry_index),
      .req_origin_x      (req_origin_x),
      .req_origin_y      (req_origin_y),
      .req_extent_w      (req_extent_w),
      .req_extent_h      (req_extent_h),
      .req_pixel_x       (req_pixel_x),
      .req_pixel_y       (req_pixel_y),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_hit           (rsp_hit),
      .rsp_winning_layer (rsp_winning_layer),
      .rsp_local_x       (rsp_local_x),
      .rsp_local_y       (rsp_local_y),
      .rsp_canvas_width  (rsp_canvas_width),
      .rsp_canvas_height (rsp_canvas_height)
   );

   always #(PERIOD / 2) clock = ~clock;

   // ---------------------------------------------------------------
   // Predictor: walk the active layers in order; a later cover wins.
   // Edges are summed without wrap, canvas size saturates.
   // ---------------------------------------------------------------
   function automatic hit_result_type resolve_pixel(input logic [CB-1:0] px,
                                                    input logic [CB-1:0] py);
      hit_result_type r;
      int unsigned n, k, right, bottom, cw, ch;
      r  = '0;
      cw = 0;
      ch = 0;
      n  = (layers_reg > MAX_L) ? MAX_L : int'(layers_reg);   // above table size acts as full
      for (k = 0; k < n; k++) begin
         right  = left_edge[k] + width[k];
         bottom = top_edge[k] + height[k];
         if (right > cw) cw = right;
         if (bottom > ch) ch = bottom;
         if (left_edge[k] <= px && px < right && top_edge[k] <= py && py < bottom) begin
            r.hit   = 1'b1;
            r.layer = IB'(k);
            r.lx    = px - left_edge[k];
            r.ly    = py - top_edge[k];
         end
      end
      r.cw = (cw > EMAX) ? (CB + 1)'(EMAX) : (CB + 1)'(cw);
      r.ch = (ch > EMAX) ? (CB + 1)'(EMAX) : (CB + 1)'(ch);
      return r;
   endfunction

   function automatic hit_result_type hres(input int h, input int l, input int x, input int y,
                                           input int cw, input int ch);
      hit_result_type r;
      r.hit   = 1'(h);
      r.layer = IB'(l);
      r.lx    = CB'(x);
      r.ly    = CB'(y);
      r.cw    = (CB + 1)'(cw);
      r.ch    = (CB + 1)'(ch);
      return r;
   endfunction

   // ---------------------------------------------------------------
   // Directed table builders
   // ---------------------------------------------------------------
   task automatic add_load(input int csr, input int e, input int ox, input int oy,
                           input int w, input int h);
      vector_row_type row;
      row.csr        = csr;
      row.item       = '0;
      row.item.op    = lphr_pkg::OP_LOAD;
      row.item.entry = IB'(e);
      row.item.ox    = CB'(ox);
      row.item.oy    = CB'(oy);
      row.item.ew    = (CB + 1)'(w);
      row.item.eh    = (CB + 1)'(h);
      row.fixed      = 1'b0;
      row.result     = '0;
      dir_rows.push_back(row);
   endtask

   task automatic add_pixel(input int csr, input int px, input int py,
                            input bit fixed = 1'b0, input hit_result_type res = '0);
      vector_row_type row;
      row.csr     = csr;
      row.item    = '0;
      row.item.op = lphr_pkg::OP_RESOLVE;
      row.item.px = CB'(px);
      row.item.py = CB'(py);
      row.fixed   = fixed;
      row.result  = res;
      dir_rows.push_back(row);
   endtask

   // ---------------------------------------------------------------
   // Random stimulus helpers
   // ---------------------------------------------------------------
   function automatic logic [CB:0] rand_extent();
      case ($urandom_range(0, 9))
         0:       return '0;                                   // empty layer
         1, 2:    return (CB + 1)'($urandom_range(0, EMAX));   // full field, drives saturation
         default: return (CB + 1)'($urandom_range(1, 256));    // small, lots of overlap
      endcase
   endfunction

   // coordinate inside, or just outside, [org, org + ext)
   function automatic logic [CB-1:0] aim(input int unsigned org, input int unsigned ext);
      int unsigned hi;
      case ($urandom_range(0, 7))
         0: return (org > 0) ? CB'(org - 1) : CB'(org);
         1: begin
            hi = org + ext;
            return (hi > CMAX) ? CB'(CMAX) : CB'(hi);
         end
         default: begin
            if (ext == 0) return CB'(org);
            hi = org + ext - 1;
            if (hi > CMAX) hi = CMAX;
            return CB'($urandom_range(org, hi));
         end
      endcase
   endfunction

   function automatic req_item_type random_item();
      req_item_type it;
      int k;
      it.op    = ($urandom_range(0, 99) < 30) ? lphr_pkg::OP_LOAD : lphr_pkg::OP_RESOLVE;
      it.entry = IB'($urandom_range(0, MAX_L - 1));
      // origins cluster near the corner most of the time so layers overlap
      it.ox    = ($urandom_range(0, 9) < 6) ? CB'($urandom_range(0, 300))
                                            : CB'($urandom_range(0, CMAX));
      it.oy    = ($urandom_range(0, 9) < 6) ? CB'($urandom_range(0, 300))
                                            : CB'($urandom_range(0, CMAX));
      it.ew    = rand_extent();
      it.eh    = rand_extent();
      it.px    = CB'($urandom_range(0, CMAX));
      it.py    = CB'($urandom_range(0, CMAX));
      // most resolves aim at a layer that is in the table right now
      if (it.op == lphr_pkg::OP_RESOLVE && $urandom_range(0, 3) != 0) begin
         k     = $urandom_range(0, MAX_L - 1);
         it.px = aim(left_edge[k], width[k]);
         it.py = aim(top_edge[k], height[k]);
      end
      return it;
   endfunction

   // ---------------------------------------------------------------
   // Sender side
   // ---------------------------------------------------------------
   // Offer one item, hold until accepted, then update the shadow table or
   // queue the expected result. An idle burst may follow.
   task automatic send(input req_item_type it, input bit fixed, input hit_result_type fres);
      req_valid       <= 1'b1;
      req_operation   <= it.op;
      req_entry_index <= it.entry;
      req_origin_x    <= it.ox;
      req_origin_y    <= it.oy;
      req_extent_w    <= it.ew;
      req_extent_h    <= it.eh;
      req_pixel_x     <= it.px;
      req_pixel_y     <= it.py;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (it.op == lphr_pkg::OP_LOAD) begin
         left_edge[it.entry] = it.ox;
         top_edge[it.entry]  = it.oy;
         width[it.entry]     = it.ew;
         height[it.entry]    = it.eh;
      end else begin
         pending_hits.push_back(fixed ? fres : resolve_pixel(it.px, it.py));
      end
      if (idle_on && $urandom_range(0, 6) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
   endtask

   // Wait for the block to go idle, then write active_layers. Loads give no
   // result, so the chain is given its full length after the last result.
   task automatic set_layers(input int value);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_hits.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= CFG_W'(value);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      layers_reg = CFG_W'(value);
   endtask

   initial begin
      int lay;
      // after reset: nothing active, all-zero result
      add_pixel(NO_CSR, 0, 0, 1'b1, hres(0, 0, 0, 0, 0, 0));
      // all layers active but the table is still all zeros
      add_pixel(8, CMAX, CMAX, 1'b1, hres(0, 0, 0, 0, 0, 0));
      // full-canvas layer 0
      add_load(NO_CSR, 0, 0, 0, 4096, 4096);
      add_pixel(NO_CSR, 0, 0, 1'b1, hres(1, 0, 0, 0, 4096, 4096));
      add_pixel(NO_CSR, CMAX, CMAX, 1'b1, hres(1, 0, CMAX, CMAX, 4096, 4096));
      // top layer at the far corner with largest extent: canvas saturates
      add_load(NO_CSR, 7, CMAX, CMAX, EMAX, EMAX);
      add_pixel(NO_CSR, CMAX, CMAX, 1'b1, hres(1, 7, 0, 0, EMAX, EMAX));
      // zero-width layer never covers
      add_load(NO_CSR, 3, 100, 200, 0, 50);
      add_pixel(NO_CSR, 100, 200, 1'b1, hres(1, 0, 100, 200, EMAX, EMAX));
      // small layer: inside, and one past each far edge, one before the near edge
      add_load(NO_CSR, 5, 10, 20, 5, 5);
      add_pixel(NO_CSR, 14, 24);
      add_pixel(NO_CSR, 15, 24);
      add_pixel(NO_CSR, 14, 25);
      add_pixel(NO_CSR, 9, 20);
      // active count above table size acts as full table
      add_pixel(15, CMAX, CMAX, 1'b1, hres(1, 7, 0, 0, EMAX, EMAX));
      // top layers inactive drop out of both hit and canvas size
      add_pixel(6, CMAX, CMAX, 1'b1, hres(1, 0, CMAX, CMAX, 4096, 4096));
      add_pixel(1, 14, 24, 1'b1, hres(1, 0, 14, 24, 4096, 4096));
      // one-column layer at the right edge
      add_load(NO_CSR, 0, CMAX, 0, 1, 4096);
      add_pixel(NO_CSR, CMAX, 0);
      add_pixel(NO_CSR, CMAX - 1, 0);
      // alternating bit patterns
      add_load(8, 1, 'hAAA, 'h555, 'h1555, 'h0AAA);
      add_load(NO_CSR, 2, 'h555, 'hAAA, 'h0AAA, 'h1555);
      add_pixel(NO_CSR, 'hAAA, 'h555);
      add_pixel(NO_CSR, 'h555, 'hAAA);

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         if (dir_rows[i].csr != NO_CSR) set_layers(dir_rows[i].csr);
         send(dir_rows[i].item, dir_rows[i].fixed, dir_rows[i].result);
      end

      // random phases, each under its own active_layers setting
      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p)
            0, 5:    lay = 8;
            1:       lay = 0;
            2:       lay = 15;
            3:       lay = 3;
            default: lay = $urandom_range(0, 15);
         endcase
         set_layers(lay);
         idle_on = (p != NUM_PHASES - 1);   // last phase runs at full rate
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            // receiver stops for a long stretch; the chain fills and stalls req
            if (p == 0 && i == 100) hold_rsp = 1'b1;
            // sender pauses until every owed result is back
            if (p == 2 && i == 120) begin
               req_valid <= 1'b0;
               do @(posedge clock); while (pending_hits.size() != 0);
            end
            send(random_item(), 1'b0, '0);
         end
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_hits.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("** layer_priority_hit_resolver_top: PASSED **");
      else
         $display("** layer_priority_hit_resolver_top: FAILED **");
      $finish;
   end

   // ---------------------------------------------------------------
   // Receiver side: ready in random stretches, idle bursts, one long hold
   // ---------------------------------------------------------------
   initial begin
      do @(posedge clock); while (reset);
      forever begin
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_rsp = 1'b0;
         end else if (idle_on && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat (idle_on ? $urandom_range(1, 24) : 1) @(posedge clock);
         end
      end
   end

   // ---------------------------------------------------------------
   // Result checker: in-order compare against the oldest expectation
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      hit_result_type got, want;
      if (!reset && rsp_valid && rsp_ready) begin
         got.hit   = rsp_hit;
         got.layer = rsp_winning_layer;
         got.lx    = rsp_local_x;
         got.ly    = rsp_local_y;
         got.cw    = rsp_canvas_width;
         got.ch    = rsp_canvas_height;
         if (pending_hits.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: hit=%0d layer=%0d local=%0d,%0d canvas=%0dx%0d",
                        got.hit, got.layer, got.lx, got.ly, got.cw, got.ch);
         end else begin
            want = pending_hits.pop_front();
            if (got.hit != want.hit || got.layer != want.layer || got.lx != want.lx ||
                got.ly != want.ly || got.cw != want.cw || got.ch != want.ch) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch: want hit=%0d layer=%0d local=%0d,%0d canvas=%0dx%0d",
                           want.hit, want.layer, want.lx, want.ly, want.cw, want.ch);
                  $display("          got  hit=%0d layer=%0d local=%0d,%0d canvas=%0dx%0d",
                           got.hit, got.layer, got.lx, got.ly, got.cw, got.ch);
               end
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == LIMIT) begin
         $display("** layer_priority_hit_resolver_top: FAILED **");
         $finish;
      end
   end

endmodule
